// File: design/fall_alert_menu_controller_top_defines.svh
// ---------------------------------------------------------------------------
// fall alert menu controller assertion macros
// shared property forms, sampled on clock and disabled during reset
// ---------------------------------------------------------------------------
`ifndef FALL_ALERT_MENU_CONTROLLER_TOP_DEFINES_SVH
`define FALL_ALERT_MENU_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define FAM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FAM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/fam_pkg.sv
// ---------------------------------------------------------------------------
// fam_pkg
// shared types, register indexes and codes of the fall alert menu controller
// ---------------------------------------------------------------------------
package fam_pkg;

   localparam int NUM_BUTTONS         = 4;
   localparam int BTN_W               = 2;
   localparam int TIME_W              = 32;
   localparam int SWITCH_W            = 3;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 24;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FALL_QUALIFY   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALERT_COOLDOWN = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BUTTON_HOLDOFF = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HOLDOFF = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CANCEL_WINDOW  = 3'd4;

   // register reset values
   localparam logic [15:0] FALL_QUALIFY_RST   = 16'd100;
   localparam logic [23:0] ALERT_COOLDOWN_RST = 24'd10000;
   localparam logic [23:0] BUTTON_HOLDOFF_RST = 24'd120000;
   localparam logic [15:0] SCREEN_HOLDOFF_RST = 16'd200;
   localparam logic [23:0] CANCEL_WINDOW_RST  = 24'd30000;

   // item kinds
   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_PASS = 1'b1;

   // screens
   localparam logic [1:0] SCR_MAIN     = 2'd0;
   localparam logic [1:0] SCR_SETTINGS = 2'd1;
   localparam logic [1:0] SCR_ALERT    = 2'd2;

   // redraw codes
   localparam logic [1:0] REDRAW_NONE     = 2'd0;
   localparam logic [1:0] REDRAW_MAIN     = 2'd1;
   localparam logic [1:0] REDRAW_SETTINGS = 2'd2;
   localparam logic [1:0] REDRAW_ALERT    = 2'd3;

   localparam logic [BTN_W-1:0] BTN_BACK = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [BTN_W-1:0]  button;
      logic [TIME_W-1:0] time_us;
      logic [TIME_W-1:0] time_ms;
      logic              tilt;
   } req_type;

   typedef struct packed {
      logic [1:0]          screen;
      logic                lights_on;
      logic                audio_on;
      logic                haptics_on;
      logic                cancelled;
      logic [1:0]          redraw;
      logic [SWITCH_W-1:0] toggled;
      logic                edge_taken;
   } rsp_type;

   // classified item between front and back
   typedef struct packed {
      logic                   kind;
      logic [NUM_BUTTONS-1:0] edge_mask;
      logic [TIME_W-1:0]      time_ms;
      logic                   tilt;
   } entry_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

endpackage

// File: design/fam_front.sv
// ---------------------------------------------------------------------------
// fam_front
// accepts requests and runs the per-button holdoff check on edges
// ---------------------------------------------------------------------------
module fam_front import fam_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   input  logic          q_ready,
   output logic          push,
   output entry_type     push_entry
);

   logic [23:0]       holdoff_ff;
   logic [23:0]       holdoff_in;
   logic [TIME_W-1:0] last_edge_ff [NUM_BUTTONS];
   logic [TIME_W-1:0] last_edge_in [NUM_BUTTONS];
   logic [TIME_W-1:0] edge_gap;
   logic              edge_ok;

   assign req_ready = q_ready;
   assign push      = req_valid && q_ready;

   // wrapping distance since this button's last accepted edge
   assign edge_gap = req_data.time_us - last_edge_ff[req_data.button];
   assign edge_ok  = (req_data.kind == KIND_EDGE) &&
                     (edge_gap >= {{(TIME_W-24){1'b0}}, holdoff_ff});

   always_comb begin
      push_entry.kind      = req_data.kind;
      push_entry.edge_mask = edge_ok ? (NUM_BUTTONS'(1) << req_data.button) : '0;
      push_entry.time_ms   = req_data.time_ms;
      push_entry.tilt      = req_data.tilt;
   end

   always_comb begin
      holdoff_in = holdoff_ff;
      if (csr.we && csr.addr == CSR_BUTTON_HOLDOFF) begin
         holdoff_in = csr.data;
      end
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         last_edge_in[i] = last_edge_ff[i];
      end
      if (push && edge_ok) begin
         last_edge_in[req_data.button] = req_data.time_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff <= BUTTON_HOLDOFF_RST;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            last_edge_ff[i] <= '0;
         end
      end else begin
         holdoff_ff <= holdoff_in;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            last_edge_ff[i] <= last_edge_in[i];
         end
      end
   end

endmodule

// File: design/fam_queue.sv
// ---------------------------------------------------------------------------
// fam_queue
// short fifo of classified items between front and back
// ---------------------------------------------------------------------------
`include "fall_alert_menu_controller_top_defines.svh"

module fam_queue import fam_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      q_ready,
   input  logic      pop,
   output logic      q_valid,
   output entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign q_ready    = (count_ff != CNT_W'(DEPTH));
   assign q_valid    = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `FAM_ASSERT_IMP(a_queue_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count overflow")
   `FAM_ASSERT_NEXT(a_queue_drain, pop && !push, count_ff == $past(count_ff) - 1'b1, "queue count off")

endmodule

// File: design/fam_back.sv
// ---------------------------------------------------------------------------
// fam_back
// carries out edge and loop-pass items: tilt alert, acknowledge, menu, switches
// ---------------------------------------------------------------------------
`include "fall_alert_menu_controller_top_defines.svh"

module fam_back import fam_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  logic          q_valid,
   input  entry_type     q_entry,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   logic [15:0]            fall_qualify_ff, fall_qualify_in;
   logic [23:0]            alert_cooldown_ff, alert_cooldown_in;
   logic [15:0]            screen_holdoff_ff, screen_holdoff_in;
   logic [23:0]            cancel_window_ff, cancel_window_in;

   logic [1:0]             screen_ff, screen_in;
   logic [NUM_BUTTONS-1:0] pending_ff, pending_in;
   logic [TIME_W-1:0]      tilt_since_ff, tilt_since_in;
   logic                   tilt_valid_ff, tilt_valid_in;
   logic [TIME_W-1:0]      cooldown_until_ff, cooldown_until_in;
   logic [TIME_W-1:0]      alert_start_ff, alert_start_in;
   logic [TIME_W-1:0]      last_change_ff, last_change_in;
   logic [SWITCH_W-1:0]    switch_ff, switch_in;
   logic                   cancel_ff, cancel_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [TIME_W-1:0]      now;
   logic [1:0]             scr_cur;
   logic                   tilt_open;
   logic [TIME_W-1:0]      since_eff;
   logic                   qualified;
   logic [TIME_W-1:0]      alert_age;
   logic                   screen_ok;
   logic [1:0]             redraw;
   logic [SWITCH_W-1:0]    toggled;

   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign now       = q_entry.time_ms;
   // an out-of-range screen code is treated as main
   assign scr_cur   = (screen_ff == SCR_SETTINGS || screen_ff == SCR_ALERT) ?
                      screen_ff : SCR_MAIN;
   assign tilt_open = (scr_cur != SCR_ALERT) && !(now < cooldown_until_ff);
   assign since_eff = tilt_valid_ff ? tilt_since_ff : now;
   assign qualified = (now - since_eff) >= {16'b0, fall_qualify_ff};
   // alert raised in this pass means an acknowledgement of age zero
   assign alert_age = (tilt_open && q_entry.tilt && qualified) ? '0 : now - alert_start_ff;
   assign screen_ok = (now - last_change_ff) >= {16'b0, screen_holdoff_ff};

   always_comb begin
      fall_qualify_in   = fall_qualify_ff;
      alert_cooldown_in = alert_cooldown_ff;
      screen_holdoff_in = screen_holdoff_ff;
      cancel_window_in  = cancel_window_ff;
      if (csr.we) begin
         case (csr.addr)
            CSR_FALL_QUALIFY:   fall_qualify_in   = csr.data[15:0];
            CSR_ALERT_COOLDOWN: alert_cooldown_in = csr.data;
            CSR_SCREEN_HOLDOFF: screen_holdoff_in = csr.data[15:0];
            CSR_CANCEL_WINDOW:  cancel_window_in  = csr.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      screen_in         = screen_ff;
      pending_in        = pending_ff;
      tilt_since_in     = tilt_since_ff;
      tilt_valid_in     = tilt_valid_ff;
      cooldown_until_in = cooldown_until_ff;
      alert_start_in    = alert_start_ff;
      last_change_in    = last_change_ff;
      switch_in         = switch_ff;
      cancel_in         = cancel_ff;
      redraw            = REDRAW_NONE;
      toggled           = '0;
      rsp_valid_in      = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in       = rsp_data_ff;

      if (q_pop) begin
         rsp_valid_in = 1'b1;
         if (q_entry.kind == KIND_EDGE) begin
            pending_in = pending_ff | q_entry.edge_mask;
         end else begin
            pending_in = '0;
            screen_in  = scr_cur;

            if (tilt_open) begin
               if (q_entry.tilt) begin
                  tilt_valid_in = 1'b1;
                  tilt_since_in = since_eff;
                  if (qualified) begin
                     screen_in      = SCR_ALERT;
                     alert_start_in = now;
                     cancel_in      = 1'b0;
                     redraw         = REDRAW_ALERT;
                  end
               end else begin
                  tilt_valid_in = 1'b0;
               end
            end

            if (pending_ff != '0) begin
               case (screen_in)
                  SCR_ALERT: begin
                     // acknowledge
                     if (alert_age < {8'b0, cancel_window_ff}) begin
                        cancel_in = 1'b1;
                     end
                     cooldown_until_in = now + {8'b0, alert_cooldown_ff};
                     tilt_valid_in     = 1'b0;
                     screen_in         = SCR_MAIN;
                     redraw            = REDRAW_MAIN;
                  end
                  SCR_MAIN: begin
                     if (screen_ok) begin
                        last_change_in = now;
                        screen_in      = SCR_SETTINGS;
                        redraw         = REDRAW_SETTINGS;
                     end
                  end
                  default: begin
                     toggled   = pending_ff[SWITCH_W-1:0];
                     switch_in = switch_ff ^ toggled;
                     if (pending_ff[BTN_BACK] && screen_ok) begin
                        last_change_in = now;
                        screen_in      = SCR_MAIN;
                        redraw         = REDRAW_MAIN;
                     end
                  end
               endcase
            end
         end

         rsp_data_in.screen     = screen_in;
         rsp_data_in.lights_on  = switch_in[0];
         rsp_data_in.audio_on   = switch_in[1];
         rsp_data_in.haptics_on = switch_in[2];
         rsp_data_in.cancelled  = cancel_in;
         rsp_data_in.redraw     = redraw;
         rsp_data_in.toggled    = toggled;
         rsp_data_in.edge_taken = (q_entry.kind == KIND_EDGE) && (q_entry.edge_mask != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fall_qualify_ff   <= FALL_QUALIFY_RST;
         alert_cooldown_ff <= ALERT_COOLDOWN_RST;
         screen_holdoff_ff <= SCREEN_HOLDOFF_RST;
         cancel_window_ff  <= CANCEL_WINDOW_RST;
         screen_ff         <= SCR_MAIN;
         pending_ff        <= '0;
         tilt_since_ff     <= '0;
         tilt_valid_ff     <= 1'b0;
         cooldown_until_ff <= '0;
         alert_start_ff    <= '0;
         last_change_ff    <= '0;
         switch_ff         <= '0;
         cancel_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         fall_qualify_ff   <= fall_qualify_in;
         alert_cooldown_ff <= alert_cooldown_in;
         screen_holdoff_ff <= screen_holdoff_in;
         cancel_window_ff  <= cancel_window_in;
         screen_ff         <= screen_in;
         pending_ff        <= pending_in;
         tilt_since_ff     <= tilt_since_in;
         tilt_valid_ff     <= tilt_valid_in;
         cooldown_until_ff <= cooldown_until_in;
         alert_start_ff    <= alert_start_in;
         last_change_ff    <= last_change_in;
         switch_ff         <= switch_in;
         cancel_ff         <= cancel_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   `FAM_ASSERT_IMP(a_alert_redraw, rsp_valid_ff && rsp_data_ff.redraw == REDRAW_ALERT, rsp_data_ff.screen == SCR_ALERT, "alert redraw off alert screen")
   `FAM_ASSERT_NEXT(a_edge_latched, q_pop && q_entry.kind == KIND_EDGE && q_entry.edge_mask != '0, pending_ff != '0, "taken edge not latched")
   `FAM_ASSERT_NEXT(a_pass_consumes, q_pop && q_entry.kind == KIND_PASS, pending_ff == '0, "pass left edges pending")

endmodule

// File: design/fall_alert_menu_controller_top.sv
// ---------------------------------------------------------------------------
// fall alert menu controller
// an accepted request is queued; the back end pops it and registers its response
// throughput: one request per cycle while rsp_ready is high, set by the back end
// a response waiting on rsp_ready does not block requests until the queue fills
// reset is synchronous, active high; control registers go to defaults, no clearing pass
// ---------------------------------------------------------------------------
module fall_alert_menu_controller_top import fam_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csr_write_type csr;
   logic          q_ready;
   logic          push;
   entry_type     push_entry;
   logic          pop;
   logic          q_valid;
   entry_type     head_entry;

   assign csr.we   = csr_we;
   assign csr.addr = csr_addr;
   assign csr.data = csr_wdata;

   fam_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_ready    (q_ready),
      .push       (push),
      .push_entry (push_entry)
   );

   fam_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .q_ready    (q_ready),
      .pop        (pop),
      .q_valid    (q_valid),
      .head_entry (head_entry)
   );

   fam_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .q_valid   (q_valid),
      .q_entry   (head_entry),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
